@@ design/lsc_pkg.sv @@
// Shared types, codes and constants of the line sensor calibrate and locate block.
// Used by the divider, the controller, the datapath and the top level.
package lsc_pkg;

   localparam int SENSOR_COUNT_DEF = 8;
   localparam int ADDR_W = 4;
   localparam int RAW_W = 16;
   localparam int NORM_W = 10;
   localparam int POS_W = 13;
   localparam int NUM_W = 26;
   localparam int ACC_W = 28;
   localparam int TOT_W = 14;
   localparam int WGT_W = 14;
   localparam int PROD_W = 24;
   localparam int DIVD_W = 28;
   localparam int DIVS_W = 16;
   localparam int CSR_W = 10;

   localparam logic [NORM_W-1:0] NORM_FULL = 10'd1000;
   localparam logic [POS_W-1:0] POS_MAX = 13'd8191;
   localparam logic [NORM_W-1:0] THRESHOLD_RESET = 10'h20;
   localparam logic [RAW_W-1:0] RAW_ALL_ONES = 16'hFFFF;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] KIND_SCAN = 2'd0;
   localparam logic [1:0] KIND_REQUEST = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic CSR_WHITE_LINE = 1'b0;
   localparam logic CSR_NOISE_THRESHOLD = 1'b1;

   localparam logic [2:0] CAL_CODE_START = 3'd2;
   localparam logic [2:0] CAL_CODE_CALIB = 3'd3;

   typedef struct packed {
      logic              take_raw;
      logic              clear_entry;
      logic              load;
      logic              track;
      logic              prep;
      logic              div_norm;
      logic              div_pos;
      logic              store_norm;
      logic              mul;
      logic              add;
      logic              acc_clear;
      logic              pos_zero;
      logic              pos_store;
      logic              emit;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        kind;
      logic [2:0]        cal_state;
      logic              calibrating;
      logic              accepted;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic total_zero;
   } stat_type;

   // Position weight of a sensor: 1000 per step, counting from one.
   function automatic logic [WGT_W-1:0] sensor_weight(input logic [ADDR_W-1:0] idx);
      logic [WGT_W-1:0] w;
      w = WGT_W'((WGT_W'(idx) + WGT_W'(1)) * WGT_W'(1000));
      return w;
   endfunction

endpackage

@@ design/lsc_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by scaling and position.
// Depends on lsc_pkg for operand widths.
module lsc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsc_pkg::DIVD_W-1:0]   dividend,
   input  logic [lsc_pkg::DIVS_W-1:0]   divisor,
   output logic                         done,
   output logic [lsc_pkg::DIVD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(lsc_pkg::DIVD_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [lsc_pkg::DIVS_W-1:0]  rem_ff, rem_in;
   logic [lsc_pkg::DIVS_W-1:0]  dsr_ff, dsr_in;
   logic [lsc_pkg::DIVD_W-1:0]  quo_ff, quo_in;
   logic [lsc_pkg::DIVS_W:0]    trial;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[lsc_pkg::DIVD_W-1]};
   assign fits = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(lsc_pkg::DIVD_W);
         rem_in = '0;
         dsr_in = divisor;
         quo_in = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? lsc_pkg::DIVS_W'(trial - {1'b0, dsr_ff})
                       : trial[lsc_pkg::DIVS_W-1:0];
         quo_in = {quo_ff[lsc_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/lsc_ctrl.sv @@
// Controller: handshakes, calibration state machine and the per-sensor sequencer.
// Depends on lsc_pkg for codes and the command and status structs.
module lsc_ctrl #(
   parameter int SENSOR_COUNT = lsc_pkg::SENSOR_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [3:0]                req_sensor_index,
   input  logic                      req_last_of_scan,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  lsc_pkg::stat_type         stat,
   output lsc_pkg::cmd_type          cmd
);

   localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CLEAR, S_LOAD, S_PREP, S_DGO, S_DWAIT, S_NORM,
      S_MUL, S_ADD, S_PGO, S_PWAIT, S_EMIT
   } seq_type;

   typedef enum logic [2:0] {
      CAL_INIT = 3'd0, CAL_NOTCAL = 3'd1, CAL_START = 3'd2,
      CAL_CALIB = 3'd3, CAL_STOP = 3'd4, CAL_READY = 3'd5
   } cal_type;

   seq_type           seq_ff;
   cal_type           cal_ff;
   logic              pend_ff;
   logic              stop_ff;
   logic              track_ff;
   logic              rsp_valid_ff;
   logic [1:0]        op_ff;
   logic [3:0]        idx_ff;
   logic              last_ff;
   logic [1:0]        kind_ff;
   logic              accepted_ff;
   logic [IDX_W-1:0]  cnt_ff;
   logic              accept;
   logic              cnt_last;
   logic              out_free;
   logic              sweeping;
   logic              req_taken;

   assign accept = req_valid && req_ready;
   assign req_ready = (seq_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cnt_last = (cnt_ff == IDX_W'(SENSOR_COUNT - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sweeping = (seq_ff != S_EMIT) && (seq_ff != S_IDLE) && (seq_ff != S_DECODE);
   assign req_taken = (cal_ff == CAL_NOTCAL) || (cal_ff == CAL_CALIB) ||
                      (cal_ff == CAL_READY);

   always_comb begin
      cmd = '0;
      cmd.take_raw = accept && (req_opcode == lsc_pkg::OP_SAMPLE);
      cmd.addr = sweeping ? lsc_pkg::ADDR_W'(cnt_ff) : idx_ff;
      cmd.track = track_ff;
      cmd.kind = kind_ff;
      cmd.cal_state = cal_ff;
      cmd.calibrating = (cal_ff == CAL_START) || (cal_ff == CAL_CALIB);
      cmd.accepted = accepted_ff;
      cmd.clear_entry = (seq_ff == S_CLEAR);
      cmd.load = (seq_ff == S_LOAD);
      cmd.prep = (seq_ff == S_PREP);
      cmd.div_norm = (seq_ff == S_DGO);
      cmd.store_norm = (seq_ff == S_NORM);
      cmd.mul = (seq_ff == S_MUL);
      cmd.add = (seq_ff == S_ADD);
      cmd.pos_zero = (seq_ff == S_PGO) && stat.total_zero;
      cmd.div_pos = (seq_ff == S_PGO) && !stat.total_zero;
      cmd.pos_store = (seq_ff == S_PWAIT) && stat.div_done;
      cmd.emit = (seq_ff == S_EMIT) && out_free;
      cmd.acc_clear = (seq_ff == S_DECODE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= S_IDLE;
         cal_ff <= CAL_INIT;
         pend_ff <= 1'b0;
         stop_ff <= 1'b0;
         track_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         kind_ff <= lsc_pkg::KIND_SCAN;
         accepted_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (seq_ff)
            S_IDLE: begin
               if (accept) begin
                  seq_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               cnt_ff <= '0;
               unique case (op_ff)
                  lsc_pkg::OP_SAMPLE: begin
                     kind_ff <= lsc_pkg::KIND_SCAN;
                     accepted_ff <= 1'b0;
                     if (!last_ff) begin
                        seq_ff <= S_IDLE;
                     end else begin
                        unique case (cal_ff)
                           CAL_INIT: begin
                              cal_ff <= CAL_NOTCAL;
                              seq_ff <= S_EMIT;
                           end
                           CAL_NOTCAL: begin
                              if (pend_ff) begin
                                 pend_ff <= 1'b0;
                                 cal_ff <= CAL_START;
                              end
                              seq_ff <= S_EMIT;
                           end
                           CAL_START: begin
                              cal_ff <= CAL_CALIB;
                              seq_ff <= S_CLEAR;
                           end
                           CAL_CALIB: begin
                              track_ff <= 1'b1;
                              stop_ff <= pend_ff;
                              pend_ff <= 1'b0;
                              seq_ff <= S_LOAD;
                           end
                           CAL_STOP: begin
                              cal_ff <= CAL_READY;
                              seq_ff <= S_EMIT;
                           end
                           CAL_READY: begin
                              track_ff <= 1'b0;
                              stop_ff <= pend_ff;
                              pend_ff <= 1'b0;
                              seq_ff <= S_LOAD;
                           end
                           default: begin
                              cal_ff <= CAL_INIT;
                              seq_ff <= S_EMIT;
                           end
                        endcase
                     end
                  end
                  lsc_pkg::OP_REQUEST: begin
                     kind_ff <= lsc_pkg::KIND_REQUEST;
                     accepted_ff <= req_taken;
                     if (req_taken) begin
                        pend_ff <= 1'b1;
                     end
                     seq_ff <= S_EMIT;
                  end
                  lsc_pkg::OP_READ: begin
                     kind_ff <= lsc_pkg::KIND_READ;
                     accepted_ff <= 1'b0;
                     seq_ff <= S_EMIT;
                  end
                  default: seq_ff <= S_IDLE;
               endcase
            end
            S_CLEAR: begin
               cnt_ff <= cnt_ff + IDX_W'(1);
               if (cnt_last) begin
                  seq_ff <= S_EMIT;
               end
            end
            S_LOAD: seq_ff <= S_PREP;
            S_PREP: seq_ff <= S_DGO;
            S_DGO: seq_ff <= S_DWAIT;
            S_DWAIT: begin
               if (stat.div_done) begin
                  seq_ff <= S_NORM;
               end
            end
            S_NORM: seq_ff <= S_MUL;
            S_MUL: seq_ff <= S_ADD;
            S_ADD: begin
               cnt_ff <= cnt_ff + IDX_W'(1);
               seq_ff <= cnt_last ? S_PGO : S_LOAD;
            end
            S_PGO: begin
               seq_ff <= stat.total_zero ? S_EMIT : S_PWAIT;
               // The step of a tracking or ready state ends here.
               if (stop_ff) begin
                  cal_ff <= (cal_ff == CAL_CALIB) ? CAL_STOP : CAL_START;
               end
            end
            S_PWAIT: begin
               if (stat.div_done) begin
                  seq_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  seq_ff <= S_IDLE;
               end
            end
            default: seq_ff <= S_IDLE;
         endcase
      end
      if (accept) begin
         op_ff <= req_opcode;
         idx_ff <= req_sensor_index;
         last_ff <= req_last_of_scan;
      end
   end

endmodule

@@ design/lsc_dp.sv @@
// Datapath: configuration, per-sensor calibration entries, scaling, weighting,
// the shared divider and the result register. Depends on lsc_pkg and lsc_div.
module lsc_dp #(
   parameter int SENSOR_COUNT = lsc_pkg::SENSOR_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [lsc_pkg::CSR_W-1:0]   csr_write_data,
   input  logic [3:0]                  req_sensor_index,
   input  logic [15:0]                 req_raw_value,
   input  lsc_pkg::cmd_type            cmd,
   output lsc_pkg::stat_type           stat,
   output logic [1:0]                  rsp_reply_kind,
   output logic [12:0]                 rsp_line_position,
   output logic [2:0]                  rsp_line_state,
   output logic                        rsp_is_calibrating,
   output logic                        rsp_request_accepted,
   output logic [15:0]                 rsp_entry_minimum,
   output logic [15:0]                 rsp_entry_maximum,
   output logic [9:0]                  rsp_entry_normalized
);

   localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   logic                         white_ff;
   logic [lsc_pkg::NORM_W-1:0]   thr_ff;
   logic [lsc_pkg::RAW_W-1:0]    raw_mem [SENSOR_COUNT];
   logic [lsc_pkg::RAW_W-1:0]    min_mem [SENSOR_COUNT];
   logic [lsc_pkg::RAW_W-1:0]    max_mem [SENSOR_COUNT];
   logic [lsc_pkg::NORM_W-1:0]   norm_mem [SENSOR_COUNT];

   logic [lsc_pkg::RAW_W-1:0]    raw_ff, min_ff, max_ff, range_ff;
   logic                         zero_ff;
   logic [lsc_pkg::NUM_W-1:0]    num_ff;
   logic [lsc_pkg::NORM_W-1:0]   v_ff;
   logic                         keep_ff;
   logic [lsc_pkg::PROD_W-1:0]   prod_ff;
   logic [lsc_pkg::ACC_W-1:0]    acc_ff;
   logic [lsc_pkg::TOT_W-1:0]    tot_ff;
   logic [lsc_pkg::POS_W-1:0]    pos_ff;

   logic                         in_range, req_in_range;
   logic [IDX_W-1:0]             ai, wi;
   logic [lsc_pkg::RAW_W-1:0]    rd_raw, rd_min, rd_max, new_min, new_max;
   logic [lsc_pkg::NORM_W-1:0]   norm, v;
   logic                         div_start, div_done;
   logic [lsc_pkg::DIVD_W-1:0]   div_dividend, div_q;
   logic [lsc_pkg::DIVS_W-1:0]   div_divisor;

   assign in_range = {1'b0, cmd.addr} < 5'(SENSOR_COUNT);
   assign req_in_range = {1'b0, req_sensor_index} < 5'(SENSOR_COUNT);
   assign ai = cmd.addr[IDX_W-1:0];
   assign wi = req_sensor_index[IDX_W-1:0];

   assign rd_raw = raw_mem[ai];
   assign rd_min = min_mem[ai];
   assign rd_max = max_mem[ai];
   assign new_min = (cmd.track && (rd_raw < rd_min)) ? rd_raw : rd_min;
   assign new_max = (cmd.track && (rd_raw > rd_max)) ? rd_raw : rd_max;

   // A sensor with no range scales to zero; above its maximum it clamps to full scale.
   assign norm = zero_ff ? '0 :
                 (div_q > lsc_pkg::DIVD_W'(lsc_pkg::NORM_FULL)) ? lsc_pkg::NORM_FULL :
                 div_q[lsc_pkg::NORM_W-1:0];
   assign v = white_ff ? (lsc_pkg::NORM_FULL - norm) : norm;

   assign div_start = cmd.div_norm || cmd.div_pos;
   assign div_dividend = cmd.div_pos ? acc_ff : lsc_pkg::DIVD_W'(num_ff);
   assign div_divisor = cmd.div_pos ? lsc_pkg::DIVS_W'(tot_ff) : range_ff;

   assign stat.div_done = div_done;
   assign stat.total_zero = (tot_ff == '0);

   lsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= 1'b0;
         thr_ff <= lsc_pkg::THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lsc_pkg::CSR_WHITE_LINE: white_ff <= csr_write_data[0];
            lsc_pkg::CSR_NOISE_THRESHOLD: thr_ff <= csr_write_data;
            default: thr_ff <= thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            raw_mem[i] <= '0;
            min_mem[i] <= '0;
            max_mem[i] <= '0;
            norm_mem[i] <= '0;
         end
         pos_ff <= '0;
      end else begin
         if (cmd.take_raw && req_in_range) begin
            raw_mem[wi] <= req_raw_value;
         end
         if (cmd.clear_entry) begin
            min_mem[ai] <= lsc_pkg::RAW_ALL_ONES;
            max_mem[ai] <= '0;
            norm_mem[ai] <= '0;
         end
         if (cmd.load) begin
            min_mem[ai] <= new_min;
            max_mem[ai] <= new_max;
         end
         if (cmd.store_norm) begin
            norm_mem[ai] <= norm;
         end
         if (cmd.pos_zero) begin
            pos_ff <= '0;
         end else if (cmd.pos_store) begin
            pos_ff <= (div_q > lsc_pkg::DIVD_W'(lsc_pkg::POS_MAX)) ? lsc_pkg::POS_MAX
                                                                  : div_q[lsc_pkg::POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= rd_raw;
         min_ff <= new_min;
         max_ff <= new_max;
      end
      if (cmd.prep) begin
         num_ff <= (raw_ff > min_ff) ?
                   lsc_pkg::NUM_W'((raw_ff - min_ff) * lsc_pkg::NUM_W'(lsc_pkg::NORM_FULL)) : '0;
         range_ff <= max_ff - min_ff;
         zero_ff <= (max_ff == min_ff);
      end
      if (cmd.store_norm) begin
         v_ff <= v;
         keep_ff <= v > thr_ff;
      end
      if (cmd.mul) begin
         prod_ff <= lsc_pkg::PROD_W'(v_ff * lsc_pkg::sensor_weight(cmd.addr));
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
         tot_ff <= '0;
      end else if (cmd.add && keep_ff) begin
         acc_ff <= acc_ff + lsc_pkg::ACC_W'(prod_ff);
         tot_ff <= tot_ff + lsc_pkg::TOT_W'(v_ff);
      end
      if (cmd.emit) begin
         rsp_reply_kind <= cmd.kind;
         rsp_line_position <= pos_ff;
         rsp_line_state <= cmd.cal_state;
         rsp_is_calibrating <= cmd.calibrating;
         rsp_request_accepted <= cmd.accepted;
         if ((cmd.kind == lsc_pkg::KIND_READ) && in_range) begin
            rsp_entry_minimum <= rd_min;
            rsp_entry_maximum <= rd_max;
            rsp_entry_normalized <= norm_mem[ai];
         end else begin
            rsp_entry_minimum <= '0;
            rsp_entry_maximum <= '0;
            rsp_entry_normalized <= '0;
         end
      end
   end

endmodule

@@ design/line_sensor_calibrate_and_locate_core.sv @@
// Top level of the line sensor calibrate and locate block.
// Joins lsc_ctrl and lsc_dp; depends on lsc_pkg.
//
//   port group  direction  carries
//   req_*       in         one item: opcode, sensor index, raw value, scan-end mark
//   rsp_*       out        one item: kind, position, state, request and entry fields
//   csr_*       in         register writes: white line mode, noise threshold
//
// A sample without a scan-end mark is only decoded; a request or an entry read is
// decoded and its result emitted. A scan-end step in the calibrating or ready state
// sweeps every sensor through the shared one-bit-per-cycle divider; a nonzero weight
// total then gives the position. The start step clears one sensor entry per cycle.
// Reset is synchronous; a result waits in the output register while rsp_ready is low,
// and the next item is taken meanwhile until that item needs the register.
module line_sensor_calibrate_and_locate_core #(
   parameter int SENSOR_COUNT = lsc_pkg::SENSOR_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic [3:0]                 req_sensor_index,
   input  logic [15:0]                req_raw_value,
   input  logic                       req_last_of_scan,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_reply_kind,
   output logic [12:0]                rsp_line_position,
   output logic [2:0]                 rsp_line_state,
   output logic                       rsp_is_calibrating,
   output logic                       rsp_request_accepted,
   output logic [15:0]                rsp_entry_minimum,
   output logic [15:0]                rsp_entry_maximum,
   output logic [9:0]                 rsp_entry_normalized,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [lsc_pkg::CSR_W-1:0]  csr_write_data
);

   lsc_pkg::cmd_type   cmd;
   lsc_pkg::stat_type  stat;

   lsc_ctrl #(.SENSOR_COUNT(SENSOR_COUNT)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_sensor_index (req_sensor_index),
      .req_last_of_scan (req_last_of_scan),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .stat             (stat),
      .cmd              (cmd)
   );

   lsc_dp #(.SENSOR_COUNT(SENSOR_COUNT)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_sensor_index     (req_sensor_index),
      .req_raw_value        (req_raw_value),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_reply_kind       (rsp_reply_kind),
      .rsp_line_position    (rsp_line_position),
      .rsp_line_state       (rsp_line_state),
      .rsp_is_calibrating   (rsp_is_calibrating),
      .rsp_request_accepted (rsp_request_accepted),
      .rsp_entry_minimum    (rsp_entry_minimum),
      .rsp_entry_maximum    (rsp_entry_maximum),
      .rsp_entry_normalized (rsp_entry_normalized)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_reply_kind != lsc_pkg::KIND_READ) |->
         (rsp_entry_minimum == '0) && (rsp_entry_maximum == '0) &&
         (rsp_entry_normalized == '0))
      else $error("entry fields set in a result that is not an entry read");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_calibrating ==
         ((rsp_line_state == lsc_pkg::CAL_CODE_START) ||
          (rsp_line_state == lsc_pkg::CAL_CODE_CALIB)))
      else $error("calibrating flag disagrees with the reported state");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_reply_kind != lsc_pkg::KIND_REQUEST) |-> !rsp_request_accepted)
      else $error("request accepted flag set outside a request reply");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

endmodule

@@ tb/sv/line_sensor_calibrate_and_locate_core_tb.sv @@
// Self-checking testbench of line_sensor_calibrate_and_locate_core: scans, requests
// and entry reads go through a built-in predictor of the calibration machine.
// Depends on lsc_pkg and the block's RTL only.
module line_sensor_calibrate_and_locate_core_tb;

   localparam int NSENS = lsc_pkg::SENSOR_COUNT_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 380;

   typedef enum logic [2:0] {
      ST_INIT, ST_NOTCAL, ST_START, ST_CALIB, ST_STOP, ST_READY
   } cal_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] position;
      logic [2:0]  state;
      logic        calibrating;
      logic        accepted;
      logic [15:0] emin;
      logic [15:0] emax;
      logic [9:0]  enorm;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = '0;
   logic [3:0] req_sensor_index = '0;
   logic [15:0] req_raw_value = '0;
   logic req_last_of_scan = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_reply_kind;
   logic [12:0] rsp_line_position;
   logic [2:0] rsp_line_state;
   logic rsp_is_calibrating;
   logic rsp_request_accepted;
   logic [15:0] rsp_entry_minimum;
   logic [15:0] rsp_entry_maximum;
   logic [9:0] rsp_entry_normalized;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic [lsc_pkg::CSR_W-1:0] csr_write_data = '0;

   // Predictor state.
   logic white_mode;
   logic [9:0] threshold;
   cal_state_type cal_state;
   logic req_pending;
   logic [15:0] min_q [NSENS];
   logic [15:0] max_q [NSENS];
   logic [9:0] norm_q [NSENS];
   logic [15:0] raw_q [NSENS];
   logic [12:0] position_q;

   reply_type replies_due[$];
   int mismatches = 0;
   int unexpected = 0;
   int replies_seen = 0;
   int items_sent = 0;
   int scans_seen = 0;
   bit rsp_stall_enable = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_sensor_calibrate_and_locate_core i_dut (.*);

   initial begin
      #200_000_000;
      $display("Timeout with %0d replies still due.", replies_due.size());
      $display("FAILURE");
      $finish;
   end

   function automatic void normalize_sensors();
      longint rng, x;
      for (int i = 0; i < NSENS; i++) begin
         rng = longint'(max_q[i]) - longint'(min_q[i]);
         x = 0;
         if (rng != 0) x = ((longint'(raw_q[i]) - longint'(min_q[i])) * 1000) / rng;
         if (x < 0) x = 0;
         else if (x > 1000) x = 1000;
         norm_q[i] = 10'(x);
      end
   endfunction

   function automatic void locate_line();
      longint acc, tot, p, v;
      acc = 0;
      tot = 0;
      for (int i = 0; i < NSENS; i++) begin
         v = norm_q[i];
         if (white_mode) v = 1000 - v;
         if (v > threshold) begin
            acc += v * 1000 * (i + 1);
            tot += v;
         end
      end
      p = (tot == 0) ? 0 : acc / tot;
      position_q = (p > 8191) ? 13'd8191 : 13'(p);
   endfunction

   function automatic void step_machine();
      case (cal_state)
         ST_INIT: cal_state = ST_NOTCAL;
         ST_NOTCAL: if (req_pending) begin
            req_pending = 1'b0;
            cal_state = ST_START;
         end
         ST_START: begin
            for (int i = 0; i < NSENS; i++) begin
               min_q[i] = 16'hFFFF;
               max_q[i] = '0;
               norm_q[i] = '0;
            end
            cal_state = ST_CALIB;
         end
         ST_CALIB: begin
            for (int i = 0; i < NSENS; i++) begin
               if (raw_q[i] < min_q[i]) min_q[i] = raw_q[i];
               if (raw_q[i] > max_q[i]) max_q[i] = raw_q[i];
            end
            normalize_sensors();
            locate_line();
            if (req_pending) begin
               req_pending = 1'b0;
               cal_state = ST_STOP;
            end
         end
         ST_STOP: cal_state = ST_READY;
         ST_READY: begin
            normalize_sensors();
            locate_line();
            if (req_pending) begin
               req_pending = 1'b0;
               cal_state = ST_START;
            end
         end
         default: cal_state = ST_INIT;
      endcase
   endfunction

   // Predicts the reply, if any, of one accepted item and queues it.
   function automatic void predict_reply(logic [1:0] op, logic [3:0] idx, logic [15:0] raw,
                                         logic last);
      reply_type r;
      r = '0;
      case (op)
         lsc_pkg::OP_SAMPLE: begin
            if (idx < NSENS) raw_q[idx] = raw;
            if (!last) return;
            step_machine();
            r.kind = lsc_pkg::KIND_SCAN;
         end
         lsc_pkg::OP_REQUEST: begin
            if (cal_state inside {ST_NOTCAL, ST_CALIB, ST_READY}) begin
               req_pending = 1'b1;
               r.accepted = 1'b1;
            end
            r.kind = lsc_pkg::KIND_REQUEST;
         end
         lsc_pkg::OP_READ: begin
            if (idx < NSENS) begin
               r.emin = min_q[idx];
               r.emax = max_q[idx];
               r.enorm = norm_q[idx];
            end
            r.kind = lsc_pkg::KIND_READ;
         end
         default: return;
      endcase
      r.position = position_q;
      r.state = cal_state;
      r.calibrating = (cal_state == ST_START) || (cal_state == ST_CALIB);
      replies_due.push_back(r);
   endfunction

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Reply checker and random back-pressure.
   always @(posedge clock) begin
      reply_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_reply_kind, rsp_line_position, rsp_line_state, rsp_is_calibrating,
                 rsp_request_accepted, rsp_entry_minimum, rsp_entry_maximum,
                 rsp_entry_normalized};
         replies_seen++;
         if (got.kind == lsc_pkg::KIND_SCAN) scans_seen++;
         if (replies_due.size() == 0) begin
            unexpected++;
            mismatches++;
            if (mismatches <= 10) $display("Reply with none due: %p", got);
         end else begin
            want = replies_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Reply mismatch:\n  expected %p\n  actual   %p", want, got);
            end
         end
      end
   end

   initial begin
      int g;
      forever begin
         @(negedge clock);
         g = rsp_stall_enable ? gap_length() : 0;
         if (g == 0) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            repeat (g - 1) @(negedge clock);
         end
      end
   end

   // The previous item drops valid at a falling edge, so the next one is raised
   // no earlier than the following falling edge; the block is busy for that cycle.
   task automatic send_item(logic [1:0] op, logic [3:0] idx, logic [15:0] raw, logic last,
                            bit no_gap = 1'b0);
      int g;
      g = no_gap ? 0 : gap_length();
      repeat (g + 1) @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_sensor_index <= idx;
      req_raw_value <= raw;
      req_last_of_scan <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_reply(op, idx, raw, last);
      items_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_replies();
      while (replies_due.size() != 0) @(posedge clock);
      // Worst case in-flight work: a full sweep of the divider.
      repeat (600) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [lsc_pkg::CSR_W-1:0] value);
      drain_replies();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == lsc_pkg::CSR_WHITE_LINE) white_mode = value[0];
      else threshold = value;
   endtask

   task automatic send_scan(bit well_formed);
      int n;
      logic [15:0] base;
      base = 16'($urandom);
      n = well_formed ? NSENS : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         logic [15:0] v;
         case ($urandom_range(0, 5))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'($urandom);
            default: v = base + 16'($urandom_range(0, 4000)) - 16'd2000;
         endcase
         send_item(lsc_pkg::OP_SAMPLE, well_formed ? 4'(i) : 4'($urandom_range(0, 15)), v,
                   i == n - 1);
      end
   endtask

   task automatic test_directed();
      send_item(lsc_pkg::OP_READ, 4'd0, 16'h0, 1'b0);
      send_item(lsc_pkg::OP_REQUEST, 4'd0, 16'h0, 1'b0);
      send_item(lsc_pkg::OP_SAMPLE, 4'd15, 16'hFFFF, 1'b1);
      send_item(lsc_pkg::OP_REQUEST, 4'd0, 16'h0, 1'b0);
      send_item(lsc_pkg::OP_REQUEST, 4'd3, 16'h0, 1'b1);
      send_item(lsc_pkg::OP_SAMPLE, 4'd0, 16'h0000, 1'b1);
      send_item(lsc_pkg::OP_REQUEST, 4'd0, 16'h0, 1'b0);
      send_item(lsc_pkg::OP_SAMPLE, 4'd7, 16'h0000, 1'b1);
      send_item(OP_UNUSED, 4'd5, 16'h1234, 1'b1);
      for (int i = 0; i < NSENS; i++)
         send_item(lsc_pkg::OP_SAMPLE, 4'(i), 16'(i * 9000), i == NSENS - 1);
      send_item(lsc_pkg::OP_SAMPLE, 4'd7, 16'hFFFF, 1'b0);
      send_item(lsc_pkg::OP_SAMPLE, 4'd12, 16'h5555, 1'b1);
      send_item(lsc_pkg::OP_READ, 4'd7, 16'h0, 1'b0);
      send_item(lsc_pkg::OP_READ, 4'd15, 16'hFFFF, 1'b1);
      send_item(lsc_pkg::OP_REQUEST, 4'd0, 16'h0, 1'b0);
      send_item(lsc_pkg::OP_SAMPLE, 4'd0, 16'd30000, 1'b1);
      send_item(lsc_pkg::OP_SAMPLE, 4'd1, 16'd30000, 1'b1);
      send_item(lsc_pkg::OP_SAMPLE, 4'd2, 16'd30000, 1'b1);
   endtask

   task automatic test_random_traffic(int count);
      int pick;
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) send_scan(1'b1);
         else if (pick < 75) send_scan(1'b0);
         else if (pick < 85)
            send_item(lsc_pkg::OP_REQUEST, 4'($urandom), 16'($urandom), 1'($urandom));
         else if (pick < 97)
            send_item(lsc_pkg::OP_READ, 4'($urandom), 16'($urandom), 1'($urandom));
         else send_item(OP_UNUSED, 4'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_back_to_back();
      rsp_stall_enable = 1'b0;
      for (int i = 0; i < 40; i++)
         send_item(lsc_pkg::OP_READ, 4'($urandom), '0, 1'b0, 1'b1);
      drain_replies();
      rsp_stall_enable = 1'b1;
   endtask

   initial begin
      white_mode = 1'b0;
      threshold = lsc_pkg::THRESHOLD_RESET;
      cal_state = ST_INIT;
      req_pending = 1'b0;
      position_q = '0;
      for (int i = 0; i < NSENS; i++) begin
         min_q[i] = '0;
         max_q[i] = '0;
         norm_q[i] = '0;
         raw_q[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_back_to_back();
      write_register(lsc_pkg::CSR_WHITE_LINE, 10'h3FF);
      write_register(lsc_pkg::CSR_NOISE_THRESHOLD, 10'd0);
      test_directed();
      test_random_traffic(RANDOM_ITEMS);
      write_register(lsc_pkg::CSR_NOISE_THRESHOLD, 10'h3FF);
      test_random_traffic(RANDOM_ITEMS);
      write_register(lsc_pkg::CSR_WHITE_LINE, 10'd0);
      write_register(lsc_pkg::CSR_NOISE_THRESHOLD, 10'd1000);
      test_random_traffic(RANDOM_ITEMS);
      write_register(lsc_pkg::CSR_NOISE_THRESHOLD, 10'd300);
      test_random_traffic(RANDOM_ITEMS);
      write_register(lsc_pkg::CSR_NOISE_THRESHOLD, lsc_pkg::THRESHOLD_RESET);
      test_random_traffic(RANDOM_ITEMS);
      drain_replies();

      $display("Covered %0d items and %0d replies, %0d of them scan results,",
               items_sent, replies_seen, scans_seen);
      $display("over several register settings.");
      if (mismatches == 0 && unexpected == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ line_sensor_calibrate_and_locate_core.f @@
design/lsc_pkg.sv
design/lsc_div.sv
design/lsc_ctrl.sv
design/lsc_dp.sv
design/line_sensor_calibrate_and_locate_core.sv
tb/sv/line_sensor_calibrate_and_locate_core_tb.sv
